### hdl/dba_pkg.sv
`default_nettype none

package dba_pkg;

   localparam int CNT_W     = 16;
   localparam int ELAPSED_W = 32;
   localparam int TICK_W    = ELAPSED_W + CNT_W;
   localparam int STEP_W    = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);
   localparam logic [CNT_W-1:0]  TICKS_PER_MS_RESET = 16'd750;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMER_ENABLE = 2'd0,
      CSR_EVENT_MODE   = 2'd1,
      CSR_TICKS_PER_MS = 2'd2
   } dba_csr_index_type;

   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_LOAD    = 1'b1
   } dba_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_SETTLE,
      ST_FIN
   } dba_state_type;

   typedef struct packed {
      logic                 operation;
      logic [ELAPSED_W-1:0] delta_ms;
      logic [CNT_W-1:0]     load_value;
   } dba_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_now;
      logic             expired;
   } dba_rsp_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic cmp;
      logic div_step;
      logic settle;
      logic emit;
   } dba_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } dba_sts_type;

endpackage

`default_nettype wire

### hdl/dba_ctrl.sv
`default_nettype none

module dba_ctrl import dba_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_operation,
   input  wire dba_sts_type sts,
   output dba_cmd_type      cmd,
   output logic             req_stall
);

   dba_state_type state_ff;
   dba_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == OP_LOAD) ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL:    state_in = ST_CMP;
         ST_CMP:    state_in = sts.need_div ? ST_DIV : ST_FIN;
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: state_in = ST_FIN;
         ST_FIN: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_MUL:    cmd.mul      = 1'b1;
         ST_CMP:    cmd.cmp      = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_SETTLE: cmd.settle   = 1'b1;
         ST_FIN:    cmd.emit     = sts.out_free;
         default:   cmd          = '0;
      endcase
   end

`ifndef SYNTH
   // A result is only ever written into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result written while output register busy");

   // An accepted advance always goes on to the multiply.
   a_adv_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_operation == OP_ADVANCE)
      |=> state_ff == ST_MUL)
      else $error("advance item did not start the multiply");
`endif

endmodule

`default_nettype wire

### hdl/dba_datapath.sv
`default_nettype none

module dba_datapath import dba_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dba_cmd_type      cmd,
   input  wire dba_req_type      req_data,
   input  wire logic             timer_enable,
   input  wire logic             event_mode,
   input  wire logic [CNT_W-1:0] ticks_per_ms,
   input  wire logic             rsp_stall,
   output dba_sts_type           sts,
   output logic                  rsp_valid,
   output dba_rsp_type           rsp_data
);

   logic [CNT_W-1:0]     count_ff,   count_in;
   logic [CNT_W-1:0]     reload_ff,  reload_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 active_ff,  active_in;
   logic                 expired_ff, expired_in;
   logic [TICK_W-1:0]    ticks_ff,   ticks_in;
   logic [CNT_W-1:0]     rem_ff,     rem_in;
   logic [STEP_W-1:0]    step_ff,    step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dba_rsp_type          rsp_ff,     rsp_in;

   logic                 ticks_lt;
   logic [CNT_W:0]       rem_shift;
   logic [CNT_W:0]       rem_diff;
   logic                 rem_ge;

   assign ticks_lt  = ticks_ff < TICK_W'(count_ff);
   assign rem_shift = {rem_ff, ticks_ff[TICK_W-1]};
   assign rem_diff  = rem_shift - {1'b0, reload_ff};
   assign rem_ge    = rem_shift >= {1'b0, reload_ff};

   assign sts.need_div = active_ff && !ticks_lt && (reload_ff != '0);
   assign sts.div_last = step_ff == LAST_STEP;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in     = count_ff;
      reload_in    = reload_ff;
      elapsed_in   = elapsed_ff;
      active_in    = active_ff;
      expired_in   = expired_ff;
      ticks_in     = ticks_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         elapsed_in = req_data.delta_ms;
         expired_in = 1'b0;
         active_in  = timer_enable && !event_mode && (count_ff != '0)
                      && (req_data.delta_ms != '0);
         if (req_data.operation == OP_LOAD) begin
            count_in  = req_data.load_value;
            reload_in = req_data.load_value;
         end
      end

      if (cmd.mul) begin
         ticks_in = elapsed_ff * ticks_per_ms;
      end

      if (cmd.cmp && active_ff) begin
         if (ticks_lt) begin
            count_in = count_ff - ticks_ff[CNT_W-1:0];
         end else begin
            expired_in = 1'b1;
            ticks_in   = ticks_ff - TICK_W'(count_ff);
            rem_in     = '0;
            step_in    = '0;
            if (reload_ff == '0) begin
               count_in = '0;
            end
         end
      end

      // Restoring division, one quotient bit per cycle; only the remainder is kept.
      if (cmd.div_step) begin
         rem_in   = rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         ticks_in = {ticks_ff[TICK_W-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
      end

      if (cmd.settle) begin
         count_in = (rem_ff == '0) ? reload_ff : reload_ff - rem_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.count_now = count_ff;
         rsp_in.expired   = expired_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         reload_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      active_ff  <= active_in;
      expired_ff <= expired_in;
      ticks_ff   <= ticks_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // The partial remainder always stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < reload_ff)
      else $error("partial remainder out of range");

   // Writing a result always leaves it on offer in the next cycle.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result not presented after write");
`endif

endmodule

`default_nettype wire

### hdl/decrementer_batch_advance.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  dba_req_type (operation, delta_ms, load_value)
// rsp_      out        rsp_valid/rsp_stall  dba_rsp_type (count_now, expired)
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One item is worked on at a time. A load goes straight to write-out; an advance passes
// through multiply and compare, and one that expires with a nonzero reload value also
// through the bit-serial remainder unit (one of 48 tick bits per cycle) and a settle step.
// Reset is synchronous and active high; it clears the count, the reload value and the
// registers (ticks_per_ms returns to 750). A stalled result waits in the output register
// while the next item is taken in; the block waits only if that item finishes first.

module decrementer_batch_advance import dba_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire dba_req_type          req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output dba_rsp_type               rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_wdata
);

   // Configuration registers. Writes are always taken; an unknown index is
   // simply dropped.
   logic             timer_enable_ff, timer_enable_in;
   logic             event_mode_ff,   event_mode_in;
   logic [CNT_W-1:0] ticks_per_ms_ff, ticks_per_ms_in;

   dba_cmd_type cmd;
   dba_sts_type sts;

   assign csr_ready = 1'b1;

   always_comb begin
      timer_enable_in = timer_enable_ff;
      event_mode_in   = event_mode_ff;
      ticks_per_ms_in = ticks_per_ms_ff;
      if (csr_valid && csr_ready) begin
         case (dba_csr_index_type'(csr_index))
            CSR_TIMER_ENABLE: timer_enable_in = csr_wdata[0];
            CSR_EVENT_MODE:   event_mode_in   = csr_wdata[0];
            CSR_TICKS_PER_MS: ticks_per_ms_in = csr_wdata;
            default:          ticks_per_ms_in = ticks_per_ms_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_enable_ff <= 1'b0;
         event_mode_ff   <= 1'b0;
         ticks_per_ms_ff <= TICKS_PER_MS_RESET;
      end else begin
         timer_enable_ff <= timer_enable_in;
         event_mode_ff   <= event_mode_in;
         ticks_per_ms_ff <= ticks_per_ms_in;
      end
   end

   // The controller sequences capture, multiply, compare, remainder, settle and write-out.
   dba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .sts           (sts),
      .cmd           (cmd),
      .req_stall     (req_stall)
   );

   // The datapath holds the count, the reload value and the output register.
   dba_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .timer_enable (timer_enable_ff),
      .event_mode   (event_mode_ff),
      .ticks_per_ms (ticks_per_ms_ff),
      .rsp_stall    (rsp_stall),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

`ifndef SYNTH
   // Once an item is taken, the input side is closed in the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while one is in progress");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import dba_pkg::*;

   // This limit is there to catch a block that has hung.
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 65;

   // One row of the directed plan: the register settings that the row runs under,
   // the item itself, and, where it can be seen at once, the result it must give.
   typedef struct packed {
      logic             enable;
      logic             event_count;
      logic [CNT_W-1:0] rate;
      dba_op_type       op;
      logic [31:0]      elapsed;
      logic [CNT_W-1:0] load;
      logic             typed;
      logic [CNT_W-1:0] want_count;
      logic             want_expired;
   } plan_row_type;

   // Columns: enable, event mode, ticks per ms, operation, elapsed ms, load value,
   // whether the result is typed in, and then the typed count and expiry flag.
   localparam plan_row_type DIRECTED_PLAN [24] = '{
      // After reset the timer is disabled and both count and reload are zero.
      '{1'b0, 1'b0, 16'd750, OP_ADVANCE, 32'd1, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{1'b0, 1'b0, 16'd750, OP_LOAD, 32'd0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{1'b0, 1'b0, 16'd750, OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
      // Event-counter mode ignores elapsed time, but a load is still taken.
      '{1'b1, 1'b1, 16'd750, OP_ADVANCE, 32'd5, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
      '{1'b1, 1'b1, 16'd750, OP_LOAD, 32'd0, 16'd200, 1'b1, 16'd200, 1'b0},
      // One tick per millisecond: zero elapsed time, a short advance, an exact
      // expiry and an expiry that leaves one tick over.
      '{1'b1, 1'b0, 16'd1, OP_ADVANCE, 32'd0, 16'hFFFF, 1'b1, 16'd200, 1'b0},
      '{1'b1, 1'b0, 16'd1, OP_ADVANCE, 32'd1, 16'h0000, 1'b1, 16'd199, 1'b0},
      '{1'b1, 1'b0, 16'd1, OP_ADVANCE, 32'd199, 16'h0000, 1'b1, 16'd200, 1'b1},
      '{1'b1, 1'b0, 16'd1, OP_ADVANCE, 32'd201, 16'h0000, 1'b1, 16'd199, 1'b1},
      // A count stopped at zero does not move.
      '{1'b1, 1'b0, 16'd1, OP_LOAD, 32'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
      '{1'b1, 1'b0, 16'd1, OP_ADVANCE, 32'd5, 16'h0000, 1'b1, 16'h0000, 1'b0},
      // A reload value of one swallows any number of leftover ticks.
      '{1'b1, 1'b0, 16'd1, OP_LOAD, 32'd0, 16'd1, 1'b1, 16'd1, 1'b0},
      '{1'b1, 1'b0, 16'd1, OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1'b1, 16'd1, 1'b1},
      // Fastest rate, with the largest products.
      '{1'b1, 1'b0, 16'hFFFF, OP_LOAD, 32'd0, 16'd10, 1'b1, 16'd10, 1'b0},
      '{1'b1, 1'b0, 16'hFFFF, OP_ADVANCE, 32'd1, 16'h0000, 1'b1, 16'd5, 1'b1},
      '{1'b1, 1'b0, 16'hFFFF, OP_LOAD, 32'd0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{1'b1, 1'b0, 16'hFFFF, OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b1, 1'b0, 16'hFFFF, OP_ADVANCE, 32'd1, 16'hA5A5, 1'b0, 16'h0000, 1'b0},
      // A rate of zero yields no ticks at all.
      '{1'b1, 1'b0, 16'd0, OP_LOAD, 32'd0, 16'd100, 1'b1, 16'd100, 1'b0},
      '{1'b1, 1'b0, 16'd0, OP_ADVANCE, 32'd7, 16'h0000, 1'b1, 16'd100, 1'b0},
      '{1'b1, 1'b0, 16'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000, 1'b1, 16'd100, 1'b0},
      // Back to the reset rate.
      '{1'b1, 1'b0, 16'd750, OP_ADVANCE, 32'd1, 16'h0000, 1'b1, 16'd50, 1'b1},
      '{1'b1, 1'b0, 16'd750, OP_LOAD, 32'd0, 16'h8000, 1'b1, 16'h8000, 1'b0},
      '{1'b1, 1'b0, 16'd750, OP_ADVANCE, 32'h5555_5555, 16'h0000, 1'b0, 16'h0000, 1'b0}
   };

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   dba_req_type          req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   dba_rsp_type          rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CNT_W-1:0]     csr_wdata = '0;

   // The testbench's own copy of the timer and of its registers.
   logic             cfg_enable   = 1'b0;
   logic             cfg_event    = 1'b0;
   logic [CNT_W-1:0] cfg_tpm      = TICKS_PER_MS_RESET;
   logic [CNT_W-1:0] timer_count  = '0;
   logic [CNT_W-1:0] timer_reload = '0;

   // Counts and expiry flags still owed by the block, oldest first.
   dba_rsp_type due_counts [$];

   int mismatches      = 0;
   int cycles          = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   // The stimulus process flips hold_toggle to ask for a long hold-off; the stall
   // process alone owns the countdown.
   bit hold_toggle = 1'b0;
   bit hold_seen   = 1'b0;
   int hold_left   = 0;

   decrementer_batch_advance uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Works out the count and expiry flag for one accepted item and moves the
   // model timer on. The tick product is formed in 48 bits, so it never wraps.
   function automatic dba_rsp_type advance_timer(input dba_req_type item);
      logic [TICK_W-1:0] ticks;
      logic [TICK_W-1:0] leftover;
      dba_rsp_type       res;
      res.expired = 1'b0;
      if (item.operation == OP_LOAD) begin
         timer_reload = item.load_value;
         timer_count  = item.load_value;
      end else if (cfg_enable && !cfg_event && timer_count != '0 && item.delta_ms != '0) begin
         ticks = TICK_W'(item.delta_ms) * TICK_W'(cfg_tpm);
         if (ticks < TICK_W'(timer_count)) begin
            timer_count = timer_count - CNT_W'(ticks);
         end else begin
            ticks       = ticks - TICK_W'(timer_count);
            res.expired = 1'b1;
            if (timer_reload == '0) begin
               timer_count = '0;
            end else begin
               leftover    = ticks % TICK_W'(timer_reload);
               timer_count = (leftover == '0) ? timer_reload
                                              : timer_reload - CNT_W'(leftover);
            end
         end
      end
      res.count_now = timer_count;
      return res;
   endfunction

   // Offers one item from a falling edge, with random idle cycles first, and
   // returns on the falling edge after it has been taken. Valid is left high so
   // that back-to-back items need no gap.
   task automatic send_item(input dba_req_type item, input bit typed, input dba_rsp_type want);
      dba_rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = advance_timer(item);
      due_counts.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Stops offering and waits until every owed result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_counts.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all three registers, one after another, starting on a falling edge.
   task automatic program_regs(input logic en, input logic ev, input logic [CNT_W-1:0] rate);
      dba_csr_index_type idx [3];
      logic [CNT_W-1:0]  val [3];
      idx = '{CSR_TIMER_ENABLE, CSR_EVENT_MODE, CSR_TICKS_PER_MS};
      val = '{CNT_W'(en), CNT_W'(ev), rate};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid  <= 1'b0;
      cfg_enable  = en;
      cfg_event   = ev;
      cfg_tpm     = rate;
   endtask

   // The receiver stalls at random, or throughout a requested hold-off, which is
   // long enough for the block to fill up and stall its own input.
   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Every result taken is compared with the oldest one owed.
   always @(posedge clock) begin : check_results
      dba_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_counts.size() == 0) begin
            if (mismatches < 10) begin
               $display("Unexpected result at cycle %0d: count_now=%h expired=%b",
                        cycles, rsp_data.count_now, rsp_data.expired);
            end
            mismatches++;
         end else begin
            want = due_counts.pop_front();
            if (rsp_data.count_now !== want.count_now || rsp_data.expired !== want.expired) begin
               if (mismatches < 10) begin
                  $display("Wrong result at cycle %0d: expected count_now=%h expired=%b, %s",
                           cycles, want.count_now, want.expired,
                           $sformatf("got count_now=%h expired=%b",
                                     rsp_data.count_now, rsp_data.expired));
               end
               mismatches++;
            end
         end
      end
   end

   // A hung block ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      dba_req_type  item;
      dba_rsp_type  want;
      plan_row_type row;
      logic         en;
      logic         ev;
      logic [15:0]  rate;
      int           kind;
      logic [15:0]  divisor;

      // Synchronous reset, released on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with no idling on either side. The registers are rewritten
      // only where a row asks for a different setting, and only once the block
      // has handed back everything it owes.
      for (int r = 0; r < $size(DIRECTED_PLAN); r++) begin
         row = DIRECTED_PLAN[r];
         if (row.enable != cfg_enable || row.event_count != cfg_event || row.rate != cfg_tpm) begin
            wait_drained();
            program_regs(row.enable, row.event_count, row.rate);
         end
         item.operation  = row.op;
         item.delta_ms   = row.elapsed;
         item.load_value = row.load;
         want.count_now  = row.want_count;
         want.expired    = row.want_expired;
         send_item(item, row.typed, want);
      end

      // Random part, in phases that each run under their own register setting
      // and their own pattern of idling.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0, 7:    rate = TICKS_PER_MS_RESET;
            1:       rate = 16'd1;
            2:       rate = 16'hFFFF;
            3:       rate = 16'($urandom_range(2, 40));
            4:       rate = 16'($urandom_range(1, 65535));
            5:       rate = 16'($urandom);
            default: rate = 16'($urandom_range(1, 8));
         endcase
         en = (p == 0 || p == 7) ? 1'b1 : ($urandom_range(5) != 0);
         ev = (p == 0 || p == 7) ? 1'b0 : ($urandom_range(5) == 0);
         program_regs(en, ev, rate);

         // No idling, a sender that idles with a chance of 66 in 100, a receiver that
         // stalls as often, and both idling now and then.
         case (p % 4)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 66; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin sender_idle_pct = 16; rsp_stall_pct = 16; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // In one phase the receiver holds off for a long stretch while items
            // keep coming, and later the sender waits for the block to empty.
            if (p == 4 && n == 15) hold_toggle = ~hold_toggle;
            if (p == 4 && n == 45) wait_drained();

            // Mostly advances on the count as it stands, with elapsed times that
            // land short of, exactly on, and far past the expiry.
            if ($urandom_range(99) < 18) begin
               item.operation  = OP_LOAD;
               item.delta_ms   = $urandom;
               kind            = $urandom_range(9);
               case (kind)
                  0:          item.load_value = 16'h0000;
                  1:          item.load_value = 16'hFFFF;
                  2, 3, 4, 5: item.load_value = 16'($urandom_range(1, 64));
                  default:    item.load_value = 16'($urandom);
               endcase
            end else begin
               item.operation  = OP_ADVANCE;
               item.load_value = 16'($urandom);
               divisor         = (cfg_tpm == '0) ? 16'd1 : cfg_tpm;
               kind            = $urandom_range(11);
               case (kind)
                  0:          item.delta_ms = 32'd0;
                  1:          item.delta_ms = 32'hFFFF_FFFF;
                  2, 3:       item.delta_ms = $urandom;
                  4, 5, 6:    item.delta_ms = $urandom_range(1, 4);
                  7, 8:       item.delta_ms = 32'(timer_count / divisor) + 32'(kind - 7);
                  9:          item.delta_ms = $urandom_range(1, 1000);
                  default:    item.delta_ms = $urandom_range(0, 65535);
               endcase
            end
            send_item(item, 1'b0, '0);
         end
      end

      // Let everything owed come back, then give the block time to show any
      // stray result before the verdict.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_counts.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
